>>> rtl/clist_pkg.sv
package clist_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int MAX_NODES_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the two channels
    localparam int CMD_W    = 2;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 3;

    // Command codes (code three is ignored)
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TRAVERSE = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_EMPTY    = 3'd1,
        STS_NO_KEY   = 3'd2,
        STS_NO_VALUE = 3'd3,
        STS_FULL     = 3'd4
    } status_t;

    // Input beat
    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [FIELD_W-1:0] key;
        logic signed [FIELD_W-1:0] value;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [FIELD_W-1:0] data;
        logic                      last;
    } out_beat_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_INEW,
        S_IRD,
        S_ICMP,
        S_ILINK,
        S_DRD_H,
        S_DCMP_H,
        S_PRD,
        S_PCMP,
        S_FIX,
        S_DRD,
        S_DCMP,
        S_TRD,
        S_TCMP,
        S_RESP
    } state_t;

    // Link memory write selections
    typedef enum logic [2:0] {
        LW_NONE,
        LW_SLOT_SELF,
        LW_SLOT_NX,
        LW_CUR_SLOT,
        LW_CUR_HN,
        LW_PREV_NX
    } link_op_t;

    // Node occupancy updates
    typedef enum logic [1:0] {
        U_NONE,
        U_SET_SLOT,
        U_CLR_HEAD,
        U_CLR_CUR
    } use_op_t;

    // Head pointer updates
    typedef enum logic [1:0] {
        H_NONE,
        H_SLOT,
        H_HN,
        H_EMPTY
    } head_op_t;

    // Controller to datapath
    typedef struct packed {
        logic                load;      // capture input beat, restart walk
        logic                restart;   // walk pointer back to head, count cleared
        logic                rd;        // read node memories at walk pointer
        logic                cur_adv;   // step walk pointer along its link
        logic                cnt_inc;
        logic                slot_take; // free slot found at count
        logic                hn_save;   // keep successor of head
        logic                wr_val;    // value memory write at slot
        link_op_t            link_op;
        use_op_t             use_op;
        head_op_t            head_op;
        logic                emit;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic                data_sel;  // node value rather than zero
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic nonempty;
        logic slot_free;
        logic eq_key;
        logic eq_val;
        logic nx_head;
        logic cnt_last;
        logic out_free;
    } dp_sts_t;

endpackage

>>> rtl/clist_ctrl.sv
module clist_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [clist_pkg::CMD_W-1:0]   s_command,
    output logic                          s_ready,
    output clist_pkg::dp_cmd_t            cmd,
    input  clist_pkg::dp_sts_t            sts
);

    clist_pkg::state_t  state_reg, state_next;
    clist_pkg::status_t resp_reg, resp_next;

    // State and pending status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clist_pkg::S_IDLE;
            resp_reg  <= clist_pkg::STS_OK;
        end else begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        resp_next  = resp_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            clist_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (s_command)
                        clist_pkg::CMD_INSERT: state_next = clist_pkg::S_FREE;
                        clist_pkg::CMD_DELETE: begin
                            if (sts.nonempty) begin
                                state_next = clist_pkg::S_DRD_H;
                            end else begin
                                resp_next  = clist_pkg::STS_EMPTY;
                                state_next = clist_pkg::S_RESP;
                            end
                        end
                        clist_pkg::CMD_TRAVERSE: begin
                            if (sts.nonempty) begin
                                state_next = clist_pkg::S_TRD;
                            end else begin
                                resp_next  = clist_pkg::STS_EMPTY;
                                state_next = clist_pkg::S_RESP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // scan occupancy for the lowest free slot
            clist_pkg::S_FREE: begin
                if (sts.slot_free) begin
                    cmd.slot_take = 1'b1;
                    cmd.restart   = 1'b1;
                    state_next    = sts.nonempty ? clist_pkg::S_IRD : clist_pkg::S_INEW;
                end else if (sts.cnt_last) begin
                    resp_next  = clist_pkg::STS_FULL;
                    state_next = clist_pkg::S_RESP;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            // first node becomes the head, linked to itself
            clist_pkg::S_INEW: begin
                cmd.wr_val  = 1'b1;
                cmd.link_op = clist_pkg::LW_SLOT_SELF;
                cmd.use_op  = clist_pkg::U_SET_SLOT;
                cmd.head_op = clist_pkg::H_SLOT;
                resp_next   = clist_pkg::STS_OK;
                state_next  = clist_pkg::S_RESP;
            end
            clist_pkg::S_IRD: begin
                cmd.rd     = 1'b1;
                state_next = clist_pkg::S_ICMP;
            end
            clist_pkg::S_ICMP: begin
                if (sts.eq_key) begin
                    cmd.wr_val  = 1'b1;
                    cmd.link_op = clist_pkg::LW_SLOT_NX;
                    cmd.use_op  = clist_pkg::U_SET_SLOT;
                    state_next  = clist_pkg::S_ILINK;
                end else if (sts.nx_head || sts.cnt_last) begin
                    resp_next  = clist_pkg::STS_NO_KEY;
                    state_next = clist_pkg::S_RESP;
                end else begin
                    cmd.cur_adv = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = clist_pkg::S_IRD;
                end
            end
            clist_pkg::S_ILINK: begin
                cmd.link_op = clist_pkg::LW_CUR_SLOT;
                resp_next   = clist_pkg::STS_OK;
                state_next  = clist_pkg::S_RESP;
            end
            // delete: look at the head first
            clist_pkg::S_DRD_H: begin
                cmd.rd     = 1'b1;
                state_next = clist_pkg::S_DCMP_H;
            end
            clist_pkg::S_DCMP_H: begin
                if (sts.eq_val) begin
                    if (sts.nx_head) begin
                        cmd.use_op  = clist_pkg::U_CLR_HEAD;
                        cmd.head_op = clist_pkg::H_EMPTY;
                        resp_next   = clist_pkg::STS_OK;
                        state_next  = clist_pkg::S_RESP;
                    end else begin
                        cmd.hn_save = 1'b1;
                        state_next  = clist_pkg::S_PRD;
                    end
                end else if (sts.nx_head) begin
                    resp_next  = clist_pkg::STS_NO_VALUE;
                    state_next = clist_pkg::S_RESP;
                end else begin
                    cmd.cur_adv = 1'b1;
                    state_next  = clist_pkg::S_DRD;
                end
            end
            // walk round to the node in front of the head
            clist_pkg::S_PRD: begin
                cmd.rd     = 1'b1;
                state_next = clist_pkg::S_PCMP;
            end
            clist_pkg::S_PCMP: begin
                if (sts.nx_head) begin
                    state_next = clist_pkg::S_FIX;
                end else begin
                    cmd.cur_adv = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = sts.cnt_last ? clist_pkg::S_FIX : clist_pkg::S_PRD;
                end
            end
            clist_pkg::S_FIX: begin
                cmd.link_op = clist_pkg::LW_CUR_HN;
                cmd.use_op  = clist_pkg::U_CLR_HEAD;
                cmd.head_op = clist_pkg::H_HN;
                resp_next   = clist_pkg::STS_OK;
                state_next  = clist_pkg::S_RESP;
            end
            // delete: search behind the head
            clist_pkg::S_DRD: begin
                cmd.rd     = 1'b1;
                state_next = clist_pkg::S_DCMP;
            end
            clist_pkg::S_DCMP: begin
                if (sts.eq_val) begin
                    cmd.link_op = clist_pkg::LW_PREV_NX;
                    cmd.use_op  = clist_pkg::U_CLR_CUR;
                    resp_next   = clist_pkg::STS_OK;
                    state_next  = clist_pkg::S_RESP;
                end else begin
                    cmd.cur_adv = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (sts.nx_head || sts.cnt_last) begin
                        resp_next  = clist_pkg::STS_NO_VALUE;
                        state_next = clist_pkg::S_RESP;
                    end else begin
                        state_next = clist_pkg::S_DRD;
                    end
                end
            end
            // traverse: one beat per node
            clist_pkg::S_TRD: begin
                cmd.rd     = 1'b1;
                state_next = clist_pkg::S_TCMP;
            end
            clist_pkg::S_TCMP: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.status   = clist_pkg::STS_OK;
                    cmd.data_sel = 1'b1;
                    cmd.last     = sts.nx_head || sts.cnt_last;
                    if (sts.nx_head || sts.cnt_last) begin
                        state_next = clist_pkg::S_IDLE;
                    end else begin
                        cmd.cur_adv = 1'b1;
                        cmd.cnt_inc = 1'b1;
                        state_next  = clist_pkg::S_TRD;
                    end
                end
            end
            clist_pkg::S_RESP: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.status = resp_reg;
                    cmd.last   = 1'b1;
                    state_next = clist_pkg::S_IDLE;
                end
            end
            default: state_next = clist_pkg::S_IDLE;
        endcase
    end

    // Only the idle state takes a beat, and a beat never lands on a busy walk
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == clist_pkg::S_IDLE)
        else $error("input ready outside idle");

    // A status beat from the response state ends the command and returns to idle
    a_emit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && state_reg == clist_pkg::S_RESP) |=> state_reg == clist_pkg::S_IDLE)
        else $error("status beat did not end the command");

endmodule

>>> rtl/clist_dp.sv
module clist_dp #(
    parameter int MAX_NODES  = clist_pkg::MAX_NODES_DEF,
    parameter int DATA_WIDTH = clist_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  clist_pkg::in_beat_t   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output clist_pkg::out_beat_t  m_payload,
    input  clist_pkg::dp_cmd_t    cmd,
    output clist_pkg::dp_sts_t    sts
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int FW    = clist_pkg::FIELD_W;

    // Node pool
    logic [DATA_WIDTH-1:0] val_mem  [MAX_NODES];
    logic [IDX_W-1:0]      link_mem [MAX_NODES];
    logic [DATA_WIDTH-1:0] val_rdata_reg;
    logic [IDX_W-1:0]      link_rdata_reg;

    logic [MAX_NODES-1:0]  in_use_reg;
    logic [IDX_W-1:0]      head_reg;
    logic                  nonempty_reg;

    logic [IDX_W-1:0]      cur_reg, prev_reg, slot_reg, hn_reg, cnt_reg;
    logic [DATA_WIDTH-1:0] key_reg, val_reg;
    logic [DATA_WIDTH-1:0] key_in, val_in;
    logic [FW-1:0]         data_out;

    logic [IDX_W-1:0]      nx;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr, link_wdata;

    logic                  m_valid_reg;
    clist_pkg::out_beat_t  m_payload_reg;

    // Field width conversions, in and out
    generate
        if (DATA_WIDTH <= FW) begin : g_in_narrow
            assign key_in = s_payload.key[DATA_WIDTH-1:0];
            assign val_in = s_payload.value[DATA_WIDTH-1:0];
        end else begin : g_in_wide
            assign key_in = {{(DATA_WIDTH-FW){s_payload.key[FW-1]}}, s_payload.key};
            assign val_in = {{(DATA_WIDTH-FW){s_payload.value[FW-1]}}, s_payload.value};
        end
        if (DATA_WIDTH >= FW) begin : g_out_wide
            assign data_out = val_rdata_reg[FW-1:0];
        end else begin : g_out_narrow
            assign data_out = {{(FW-DATA_WIDTH){val_rdata_reg[DATA_WIDTH-1]}}, val_rdata_reg};
        end
    endgenerate

    // Successor of the node just read; out-of-range links fall back to node zero
    assign nx = ({1'b0, link_rdata_reg} < (IDX_W+1)'(MAX_NODES)) ? link_rdata_reg : '0;

    // Status to the controller
    always_comb begin
        sts.nonempty  = nonempty_reg;
        sts.slot_free = !in_use_reg[cnt_reg];
        sts.eq_key    = val_rdata_reg == key_reg;
        sts.eq_val    = val_rdata_reg == val_reg;
        sts.nx_head   = nx == head_reg;
        sts.cnt_last  = cnt_reg == IDX_W'(MAX_NODES - 1);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // Link write port selection
    always_comb begin
        link_we    = 1'b1;
        link_waddr = slot_reg;
        link_wdata = slot_reg;
        unique case (cmd.link_op)
            clist_pkg::LW_NONE:      link_we = 1'b0;
            clist_pkg::LW_SLOT_SELF: ;
            clist_pkg::LW_SLOT_NX:   link_wdata = nx;
            clist_pkg::LW_CUR_SLOT:  link_waddr = cur_reg;
            clist_pkg::LW_CUR_HN: begin
                link_waddr = cur_reg;
                link_wdata = hn_reg;
            end
            clist_pkg::LW_PREV_NX: begin
                link_waddr = prev_reg;
                link_wdata = nx;
            end
            default: link_we = 1'b0;
        endcase
    end

    // Node memories: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (cmd.wr_val) begin
            val_mem[slot_reg] <= val_reg;
        end
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.rd) begin
            val_rdata_reg  <= val_mem[cur_reg];
            link_rdata_reg <= link_mem[cur_reg];
        end
    end

    // Occupancy, head and list flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg   <= '0;
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
        end else begin
            case (cmd.use_op)
                clist_pkg::U_SET_SLOT: in_use_reg[slot_reg] <= 1'b1;
                clist_pkg::U_CLR_HEAD: in_use_reg[head_reg] <= 1'b0;
                clist_pkg::U_CLR_CUR:  in_use_reg[cur_reg]  <= 1'b0;
                default: ;
            endcase
            case (cmd.head_op)
                clist_pkg::H_SLOT: begin
                    head_reg     <= slot_reg;
                    nonempty_reg <= 1'b1;
                end
                clist_pkg::H_HN: head_reg <= hn_reg;
                clist_pkg::H_EMPTY: begin
                    head_reg     <= '0;
                    nonempty_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Walk pointers and step count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load || cmd.restart) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key_in;
            val_reg <= val_in;
        end
        if (cmd.load || cmd.restart) begin
            cur_reg <= head_reg;
        end else if (cmd.cur_adv) begin
            prev_reg <= cur_reg;
            cur_reg  <= nx;
        end
        if (cmd.slot_take) begin
            slot_reg <= cnt_reg;
        end
        if (cmd.hn_save) begin
            hn_reg <= nx;
        end
    end

    // Result register: holds a beat until taken, refilled in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_payload_reg.status <= cmd.status;
            m_payload_reg.data   <= cmd.data_sel ? data_out : '0;
            m_payload_reg.last   <= cmd.last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // A pending result beat is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result beat overwritten");

    // The head of a nonempty list is an occupied node
    a_head_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        nonempty_reg |-> in_use_reg[head_reg])
        else $error("head node not in use");

    // An empty list holds no nodes
    a_empty_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        !nonempty_reg |-> in_use_reg == '0)
        else $error("nodes in use with empty list");

    // Allocation only takes a free slot
    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.use_op == clist_pkg::U_SET_SLOT |-> !in_use_reg[slot_reg])
        else $error("allocated slot already in use");

endmodule

>>> rtl/circular_list_engine.sv
// Channel  Ports                        Direction  Beat
// -------  ---------------------------  ---------  ---------------------------
// input    s_valid s_ready s_payload    in         command, key, value
// result   m_valid m_ready m_payload    out        status, data, last
//
// One command at a time; a result waits in an output register while the next
// command is taken. Insert: scans occupancy for the lowest free slot, then
// walks the list to the node holding the key. Delete: walks to the match,
// then round to the head's predecessor when the head goes. Traverse: visits
// each node. Every walk step reads the node memories, whose read is registered,
// then compares. Reset empties the list at once, no clearing pass.
// A stalled result channel holds a traverse at its next node.
module circular_list_engine #(
    parameter int MAX_NODES  = clist_pkg::MAX_NODES_DEF,
    parameter int DATA_WIDTH = clist_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clist_pkg::in_beat_t   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output clist_pkg::out_beat_t  m_payload
);

    clist_pkg::dp_cmd_t cmd;
    clist_pkg::dp_sts_t sts;

    clist_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_payload.command),
        .s_ready   (s_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    clist_dp #(
        .MAX_NODES  (MAX_NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> sim/testbench.sv
module testbench;

    localparam int NODES        = clist_pkg::MAX_NODES_DEF;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int RANDOM_ITEMS = 282;
    localparam logic [clist_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    clist_pkg::in_beat_t  s_payload = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    clist_pkg::out_beat_t m_payload;

    circular_list_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the node pool
    logic signed [clist_pkg::FIELD_W-1:0] node_val  [NODES];
    int                                   node_nxt  [NODES];
    logic                                 node_used [NODES];
    int                                   head_idx  = 0;
    logic                                 list_live = 1'b0;

    clist_pkg::in_beat_t  cmd_q[$];
    clist_pkg::out_beat_t result_q[$];

    int        n_in       = 0;
    int        fail_cnt   = 0;
    int        idle_cnt   = 0;
    int        gap_left   = 0;
    int        burst_left = 1;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;
    logic [31:0] rx_cyc   = '0;

    function automatic clist_pkg::out_beat_t make_result(clist_pkg::status_t st,
                                                         logic signed [clist_pkg::FIELD_W-1:0] d,
                                                         logic l);
        clist_pkg::out_beat_t r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        return r;
    endfunction

    // Mostly a small pool of values so keys hit; sometimes anything at all
    function automatic logic signed [clist_pkg::FIELD_W-1:0] pick_value();
        logic signed [clist_pkg::FIELD_W-1:0] pool [8];
        pool[0] = 32'sh80000000;
        pool[1] = 32'sh7fffffff;
        pool[2] = 32'sh00000000;
        pool[3] = 32'shffffffff;
        pool[4] = 32'sh00000001;
        pool[5] = 32'sh55555555;
        pool[6] = 32'shaaaaaaaa;
        pool[7] = 32'sh00000007;
        if ($urandom_range(0, 9) < 8)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic add_cmd(logic [clist_pkg::CMD_W-1:0] c,
                           logic signed [clist_pkg::FIELD_W-1:0] k,
                           logic signed [clist_pkg::FIELD_W-1:0] v);
        clist_pkg::in_beat_t b;
        b.command = c;
        b.key     = k;
        b.value   = v;
        cmd_q.push_back(b);
    endtask

    // Apply one command to the shadow list and queue the results it gives
    task automatic predict_beat(clist_pkg::in_beat_t b);
        int                 slot, cur, prev, k, hn;
        clist_pkg::status_t st;
        logic               fin;
        st = clist_pkg::STS_OK;
        case (b.command)
            clist_pkg::CMD_INSERT: begin
                slot = -1;
                for (k = 0; k < NODES; k++)
                    if (!node_used[k] && slot < 0) slot = k;
                if (slot < 0) begin
                    st = clist_pkg::STS_FULL;
                end else if (!list_live) begin
                    node_val[slot]  = b.value;
                    node_nxt[slot]  = slot;
                    node_used[slot] = 1'b1;
                    head_idx        = slot;
                    list_live       = 1'b1;
                end else begin
                    // key missing: slot stays free
                    st  = clist_pkg::STS_NO_KEY;
                    cur = head_idx;
                    for (k = 0; k < NODES; k++) begin
                        if (node_val[cur] == b.key) begin
                            node_val[slot]  = b.value;
                            node_nxt[slot]  = node_nxt[cur];
                            node_nxt[cur]   = slot;
                            node_used[slot] = 1'b1;
                            st = clist_pkg::STS_OK;
                            break;
                        end
                        cur = node_nxt[cur];
                        if (cur == head_idx) break;
                    end
                end
                result_q.push_back(make_result(st, '0, 1'b1));
            end
            clist_pkg::CMD_DELETE: begin
                if (!list_live) begin
                    st = clist_pkg::STS_EMPTY;
                end else if (node_val[head_idx] == b.value) begin
                    hn = node_nxt[head_idx];
                    if (hn == head_idx) begin
                        node_used[head_idx] = 1'b0;
                        list_live = 1'b0;
                        head_idx  = 0;
                    end else begin
                        // walk round to the head's predecessor
                        cur = head_idx;
                        for (k = 0; k < NODES && node_nxt[cur] != head_idx; k++)
                            cur = node_nxt[cur];
                        node_nxt[cur]       = hn;
                        node_used[head_idx] = 1'b0;
                        head_idx            = hn;
                    end
                end else begin
                    st   = clist_pkg::STS_NO_VALUE;
                    prev = head_idx;
                    cur  = node_nxt[prev];
                    for (k = 0; k < NODES && cur != head_idx; k++) begin
                        if (node_val[cur] == b.value) begin
                            node_nxt[prev] = node_nxt[cur];
                            node_used[cur] = 1'b0;
                            st = clist_pkg::STS_OK;
                            break;
                        end
                        prev = cur;
                        cur  = node_nxt[cur];
                    end
                end
                result_q.push_back(make_result(st, '0, 1'b1));
            end
            clist_pkg::CMD_TRAVERSE: begin
                if (!list_live) begin
                    result_q.push_back(make_result(clist_pkg::STS_EMPTY, '0, 1'b1));
                end else begin
                    cur = head_idx;
                    for (k = 0; k < NODES; k++) begin
                        fin = (node_nxt[cur] == head_idx) || (k == NODES - 1);
                        result_q.push_back(make_result(clist_pkg::STS_OK, node_val[cur], fin));
                        if (fin) break;
                        cur = node_nxt[cur];
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Sender: bursts of beats with random gaps in between
    always @(posedge aclk) begin : drive_p
        logic show;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            show = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                predict_beat(s_payload);
                n_in <= n_in + 1;
            end
            if (!show) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (cmd_q.size() > 0) begin
                    s_payload <= cmd_q.pop_front();
                    show = 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
                    end
                end
            end
            s_valid <= show;
        end
    end

    // Receiver: one long hold-off, otherwise a rotating stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            rx_cyc <= rx_cyc + 1;
            case (rx_cyc[7:6])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= ($urandom_range(0, 1) == 1);
                2'd2:    m_ready <= ($urandom_range(0, 4) != 0);
                default: m_ready <= (rx_cyc[2:0] < 3'd5);
            endcase
        end
    end

    // Result checker
    always @(posedge aclk) begin : check_p
        clist_pkg::out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result beat: status %0d data %0h last %0b",
                       m_payload.status, m_payload.data, m_payload.last);
                fail_cnt++;
            end else begin
                want = result_q.pop_front();
                if (m_payload.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_payload.status);
                    fail_cnt++;
                end
                if (m_payload.data !== want.data) begin
                    $error("data: expected %0h, got %0h", want.data, m_payload.data);
                    fail_cnt++;
                end
                if (m_payload.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_payload.last);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        int i, r, n_total;
        logic [clist_pkg::CMD_W-1:0] c;
        for (i = 0; i < NODES; i++) begin
            node_val[i]  = '0;
            node_nxt[i]  = 0;
            node_used[i] = 1'b0;
        end

        // Directed: empty list cases, head handling, unused code, full pool
        add_cmd(clist_pkg::CMD_TRAVERSE, 32'sh0, 32'sh0);
        add_cmd(clist_pkg::CMD_DELETE,   32'sh0, 32'sh7fffffff);
        add_cmd(clist_pkg::CMD_INSERT,   32'sh12345678, 32'sh80000000);
        add_cmd(clist_pkg::CMD_INSERT,   32'sh7fffffff, 32'sh1);
        add_cmd(clist_pkg::CMD_INSERT,   32'sh80000000, 32'sh7fffffff);
        add_cmd(clist_pkg::CMD_TRAVERSE, 32'shffffffff, 32'shffffffff);
        add_cmd(clist_pkg::CMD_DELETE,   32'sh0, 32'sh12345);
        add_cmd(clist_pkg::CMD_DELETE,   32'sh0, 32'sh80000000);
        add_cmd(clist_pkg::CMD_DELETE,   32'sh0, 32'sh7fffffff);
        add_cmd(CMD_UNUSED,              32'shffffffff, 32'shffffffff);
        add_cmd(clist_pkg::CMD_INSERT,   32'sh0, 32'shffffffff);
        for (i = 1; i < NODES; i++)
            add_cmd(clist_pkg::CMD_INSERT, 32'shffffffff, i * 32'sh11111111);
        add_cmd(clist_pkg::CMD_INSERT,   32'shffffffff, 32'sh5);
        add_cmd(clist_pkg::CMD_TRAVERSE, 32'sh0, 32'sh0);

        // Random: alternate delete-heavy and insert-heavy stretches
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (((i / 40) % 2) == 0)
                c = (r < 20) ? clist_pkg::CMD_INSERT : (r < 75) ? clist_pkg::CMD_DELETE :
                    (r < 98) ? clist_pkg::CMD_TRAVERSE : CMD_UNUSED;
            else
                c = (r < 60) ? clist_pkg::CMD_INSERT : (r < 78) ? clist_pkg::CMD_DELETE :
                    (r < 97) ? clist_pkg::CMD_TRAVERSE : CMD_UNUSED;
            add_cmd(c, pick_value(), pick_value());
        end
        n_total = cmd_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // every beat taken and every expected result seen
        do @(posedge aclk);
        while (n_in < n_total || result_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
